### hw/rtl/sspc_pkg.sv
// Types, codes and the verdict function of the servo status packet checker.
// No dependencies.
package sspc_pkg;

	typedef enum logic [1:0] {
		MODE_BEGIN   = 2'd0,
		MODE_BYTE    = 2'd1,
		MODE_TIMEOUT = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		VERDICT_OK        = 3'd0,
		VERDICT_TIMEOUT   = 3'd1,
		VERDICT_HEADER    = 3'd2,
		VERDICT_ID        = 3'd3,
		VERDICT_LENGTH    = 3'd4,
		VERDICT_CHECKSUM  = 3'd5,
		VERDICT_BROADCAST = 3'd6
	} verdict_t;

	localparam logic REG_PACKET_FORMAT = 1'b0;
	localparam logic REG_BROADCAST_ID  = 1'b1;

	localparam logic [7:0] HEADER_BYTE   = 8'hFF;
	localparam logic [7:0] UNKNOWN_COUNT = 8'd255;
	localparam logic [7:0] MAX_COUNT     = 8'd255;
	localparam logic [7:0] SUM_START     = 8'd3;
	localparam logic [7:0] SUM_GOOD      = 8'hFF;
	localparam logic [7:0] MIN_CHECKED   = 8'd3;

	// Field positions of the two packet layouts
	localparam logic [7:0] ID_POS_P1   = 8'd3;
	localparam logic [7:0] LEN_POS_P1  = 8'd4;
	localparam logic [7:0] INST_POS_P1 = 8'd5;
	localparam logic [7:0] ERR_POS_P1  = 8'd5;
	localparam logic [7:0] ID_POS_P2   = 8'd4;
	localparam logic [7:0] LEN_POS_P2  = 8'd5;
	localparam logic [7:0] INST_POS_P2 = 8'd7;
	localparam logic [7:0] ERR_POS_P2  = 8'd8;

	typedef struct packed {
		logic       header_good;
		logic [7:0] count;
		logic [7:0] target_count;
		logic [7:0] target_id;
		logic [7:0] seen_id;
		logic [7:0] seen_length;
		logic [7:0] running_sum;
	} judge_in_t;

	function automatic verdict_t judge(input judge_in_t j, input logic timed_out,
			input logic [7:0] bcast_id, input logic [7:0] inst_pos);
		verdict_t v;
		v = VERDICT_OK;
		if (j.target_id == bcast_id) begin
			v = VERDICT_BROADCAST;
		end else if (timed_out && (j.target_count != UNKNOWN_COUNT)) begin
			v = VERDICT_TIMEOUT;
		end else if (j.count > MIN_CHECKED) begin
			if (!j.header_good) begin
				v = VERDICT_HEADER;
			end else if (j.seen_id != j.target_id) begin
				v = VERDICT_ID;
			end else if ((j.count < inst_pos) || (j.seen_length != (j.count - inst_pos))) begin
				v = VERDICT_LENGTH;
			end else if (j.running_sum != SUM_GOOD) begin
				v = VERDICT_CHECKSUM;
			end
		end
		return v;
	endfunction

endpackage

### hw/rtl/servo_status_packet_checker_unit.sv
// Servo status packet checker: top level, input register, window state and verdict register.
// Depends on sspc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item: a begin
//   (expected id and byte count), a received byte, or a receive timeout.
//   Output channel (out_valid / out_stall) carries one verdict transaction per
//   closed window: verdict code, byte count, error byte and first data word.
//   Configuration (cfg_we, cfg_index, cfg_data) selects the packet layout and the
//   broadcast id; write only while no transaction is in flight.
// Path: an item is registered in the input register on acceptance, and its verdict,
//   if any, is then registered in the output register, which drives out_valid.
// Throughput: one item per cycle while in_stall is low; the window update between the
//   input register and the state registers is combinational.
// Reset: the window closes, counters and captured fields clear, header check reads
//   good, layout is protocol one and the broadcast id is 254.
// Stall: the output register holds its verdict while out_stall is high; the input
//   register keeps taking items while it is empty and only backs up in_stall when
//   a verdict-producing item cannot move into the full output register.
module servo_status_packet_checker_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           expected_id,
	input  logic [7:0]           expected_count,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           verdict,
	output logic [7:0]           byte_count,
	output logic [7:0]           error_byte,
	output logic [15:0]          data_word,
	// configuration
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data
);
	import sspc_pkg::*;

	// configuration registers
	logic       packet_format_q;
	logic [7:0] broadcast_id_q;

	// input register
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] byte_s1;
	logic [7:0] exp_id_s1;
	logic [7:0] exp_count_s1;

	// window state
	logic        window_open_q;
	logic [7:0]  count_q;
	logic [7:0]  target_count_q;
	logic [7:0]  target_id_q;
	logic        header_good_q;
	logic [7:0]  seen_id_q;
	logic [7:0]  seen_length_q;
	logic [7:0]  seen_error_q;
	logic [15:0] seen_data_q;
	logic [7:0]  running_sum_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  verdict_q;
	logic [7:0]  byte_count_q;
	logic [7:0]  error_byte_q;
	logic [15:0] data_word_q;

	// next-state values
	logic        window_open_d;
	logic [7:0]  count_d;
	logic [7:0]  target_count_d;
	logic [7:0]  target_id_d;
	logic        header_good_d;
	logic [7:0]  seen_id_d;
	logic [7:0]  seen_length_d;
	logic [7:0]  seen_error_d;
	logic [15:0] seen_data_d;
	logic [7:0]  running_sum_d;
	logic        emit;
	logic        timed_out;
	verdict_t    verdict_d;
	judge_in_t   judge_in;

	logic [7:0] id_pos, len_pos, inst_pos, err_pos;
	logic       out_free, advance_s1;

	assign id_pos   = packet_format_q ? ID_POS_P2   : ID_POS_P1;
	assign len_pos  = packet_format_q ? LEN_POS_P2  : LEN_POS_P1;
	assign inst_pos = packet_format_q ? INST_POS_P2 : INST_POS_P1;
	assign err_pos  = packet_format_q ? ERR_POS_P2  : ERR_POS_P1;

	// the output register frees up when empty or being taken this cycle
	assign out_free   = !out_valid_q || !out_stall;
	// hold an item in s1 only if it must emit and the output register is busy
	assign advance_s1 = valid_s1 && (!emit || out_free);
	assign in_stall   = valid_s1 && !advance_s1;

	always_comb begin
		window_open_d  = window_open_q;
		count_d        = count_q;
		target_count_d = target_count_q;
		target_id_d    = target_id_q;
		header_good_d  = header_good_q;
		seen_id_d      = seen_id_q;
		seen_length_d  = seen_length_q;
		seen_error_d   = seen_error_q;
		seen_data_d    = seen_data_q;
		running_sum_d  = running_sum_q;
		emit           = 1'b0;
		timed_out      = 1'b0;
		unique case (mode_s1)
			MODE_BEGIN: begin
				// open a fresh window, dropping any open one
				target_id_d    = exp_id_s1;
				target_count_d = exp_count_s1;
				count_d        = '0;
				header_good_d  = 1'b1;
				seen_id_d      = '0;
				seen_length_d  = '0;
				seen_error_d   = '0;
				seen_data_d    = '0;
				running_sum_d  = '0;
				window_open_d  = 1'b1;
				if (exp_count_s1 == '0) begin
					emit          = 1'b1;
					window_open_d = 1'b0;
				end
			end
			MODE_TIMEOUT: begin
				if (window_open_q) begin
					emit          = 1'b1;
					timed_out     = 1'b1;
					window_open_d = 1'b0;
				end
			end
			MODE_BYTE: begin
				if (window_open_q) begin
					if ((count_q < SUM_START) && (byte_s1 != HEADER_BYTE))
						header_good_d = 1'b0;
					if (count_q == id_pos)
						seen_id_d = byte_s1;
					if (count_q == len_pos)
						seen_length_d = byte_s1;
					if (count_q == err_pos)
						seen_error_d = byte_s1;
					if (count_q == err_pos + 8'd1)
						seen_data_d[7:0] = byte_s1;
					if (count_q == err_pos + 8'd2)
						seen_data_d[15:8] = byte_s1;
					if (count_q >= SUM_START)
						running_sum_d = running_sum_q + byte_s1;
					if (count_q < MAX_COUNT)
						count_d = count_q + 8'd1;
					// close on the expected count or on a saturated counter
					if ((count_d == target_count_q) || (count_d == MAX_COUNT)) begin
						emit          = 1'b1;
						window_open_d = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign judge_in = '{
		header_good:  header_good_d,
		count:        count_d,
		target_count: target_count_d,
		target_id:    target_id_d,
		seen_id:      seen_id_d,
		seen_length:  seen_length_d,
		running_sum:  running_sum_d
	};
	assign verdict_d = judge(judge_in, timed_out, broadcast_id_q, inst_pos);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_format_q <= 1'b0;
			broadcast_id_q  <= 8'd254;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PACKET_FORMAT: packet_format_q <= cfg_data[0];
				REG_BROADCAST_ID:  broadcast_id_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: load when empty or when its item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1      <= mode;
			byte_s1      <= rx_byte;
			exp_id_s1    <= expected_id;
			exp_count_s1 <= expected_count;
		end
	end

	// window state: advance once per item leaving s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_open_q  <= 1'b0;
			count_q        <= '0;
			target_count_q <= '0;
			target_id_q    <= '0;
			header_good_q  <= 1'b1;
			seen_id_q      <= '0;
			seen_length_q  <= '0;
			seen_error_q   <= '0;
			seen_data_q    <= '0;
			running_sum_q  <= '0;
		end else if (advance_s1) begin
			window_open_q  <= window_open_d;
			count_q        <= count_d;
			target_count_q <= target_count_d;
			target_id_q    <= target_id_d;
			header_good_q  <= header_good_d;
			seen_id_q      <= seen_id_d;
			seen_length_q  <= seen_length_d;
			seen_error_q   <= seen_error_d;
			seen_data_q    <= seen_data_d;
			running_sum_q  <= running_sum_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			verdict_q    <= verdict_d;
			byte_count_q <= count_d;
			error_byte_q <= seen_error_d;
			data_word_q  <= seen_data_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign verdict    = verdict_q;
	assign byte_count = byte_count_q;
	assign error_byte = error_byte_q;
	assign data_word  = data_word_q;

endmodule

### dv/tb_servo_status_packet_checker_unit.sv
`timescale 1ns / 1ps
// Testbench for servo_status_packet_checker_unit: directed and random packet windows,
// checked against a cycle-free behavioral predictor. Depends on sspc_pkg and the RTL top.
module tb_servo_status_packet_checker_unit;
	import sspc_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned MAX_REPORTS = 40;

	typedef struct {
		verdict_t    verdict;
		logic [7:0]  byte_count;
		logic [7:0]  error_byte;
		logic [15:0] data_word;
	} verdict_rec_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [7:0]  rx_byte;
	logic [7:0]  expected_id;
	logic [7:0]  expected_count;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  verdict;
	logic [7:0]  byte_count;
	logic [7:0]  error_byte;
	logic [15:0] data_word;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	servo_status_packet_checker_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.rx_byte        (rx_byte),
		.expected_id    (expected_id),
		.expected_count (expected_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict        (verdict),
		.byte_count     (byte_count),
		.error_byte     (error_byte),
		.data_word      (data_word),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Predictor copy of the registers and the window state
	logic        fmt_sel;
	logic [7:0]  bcast;
	logic        win_open;
	logic [7:0]  n_rcvd;
	logic [7:0]  want_count;
	logic [7:0]  want_id;
	logic        hdr_ok;
	logic [7:0]  cap_id;
	logic [7:0]  cap_len;
	logic [7:0]  cap_err;
	logic [15:0] cap_data;
	logic [7:0]  sum8;

	verdict_rec_t pending_verdicts[$];

	// Stimulus side view of the registers, used to build packets
	logic        drv_fmt;
	logic [7:0]  drv_bcast;
	logic [7:0]  pkt[$];
	bit          steady_in;
	bit          steady_out;

	int unsigned useful_items;
	int unsigned verdicts_checked;
	int unsigned mismatches;
	int unsigned cfg_writes;
	int unsigned cycles;
	int unsigned verdict_hits[8];

	// ---------------------------------------------------------------- predictor

	function automatic verdict_t grade(input bit timed_out);
		logic [7:0] inst_at;
		inst_at = fmt_sel ? INST_POS_P2 : INST_POS_P1;
		if (want_id == bcast)
			return VERDICT_BROADCAST;
		if (timed_out && want_count != UNKNOWN_COUNT)
			return VERDICT_TIMEOUT;
		if (n_rcvd > MIN_CHECKED) begin
			if (!hdr_ok)
				return VERDICT_HEADER;
			if (cap_id != want_id)
				return VERDICT_ID;
			if (n_rcvd < inst_at || cap_len != n_rcvd - inst_at)
				return VERDICT_LENGTH;
			if (sum8 != SUM_GOOD)
				return VERDICT_CHECKSUM;
		end
		return VERDICT_OK;
	endfunction

	task automatic close_window(input bit timed_out);
		verdict_rec_t rec;
		rec.verdict    = grade(timed_out);
		rec.byte_count = n_rcvd;
		rec.error_byte = cap_err;
		rec.data_word  = cap_data;
		pending_verdicts.push_back(rec);
		win_open = 1'b0;
	endtask

	task automatic model_item(input logic [1:0] m, input logic [7:0] b, input logic [7:0] id,
			input logic [7:0] cnt);
		logic [7:0] id_at;
		logic [7:0] len_at;
		logic [7:0] err_at;
		id_at  = fmt_sel ? ID_POS_P2 : ID_POS_P1;
		len_at = fmt_sel ? LEN_POS_P2 : LEN_POS_P1;
		err_at = fmt_sel ? ERR_POS_P2 : ERR_POS_P1;
		if (m == MODE_BEGIN) begin
			// a begin drops any open window silently and restarts capture
			useful_items++;
			want_id    = id;
			want_count = cnt;
			n_rcvd     = '0;
			hdr_ok     = 1'b1;
			cap_id     = '0;
			cap_len    = '0;
			cap_err    = '0;
			cap_data   = '0;
			sum8       = '0;
			win_open   = 1'b1;
			if (cnt == 8'd0)
				close_window(1'b0);
		end else if (m == MODE_TIMEOUT) begin
			if (win_open) begin
				useful_items++;
				close_window(1'b1);
			end
		end else if (m == MODE_BYTE && win_open) begin
			useful_items++;
			if (n_rcvd < SUM_START && b != HEADER_BYTE)
				hdr_ok = 1'b0;
			if (n_rcvd == id_at)
				cap_id = b;
			if (n_rcvd == len_at)
				cap_len = b;
			if (n_rcvd == err_at)
				cap_err = b;
			if (n_rcvd == err_at + 8'd1)
				cap_data[7:0] = b;
			if (n_rcvd == err_at + 8'd2)
				cap_data[15:8] = b;
			if (n_rcvd >= SUM_START)
				sum8 = sum8 + b;
			if (n_rcvd < MAX_COUNT)
				n_rcvd = n_rcvd + 8'd1;
			if (n_rcvd == want_count || n_rcvd == MAX_COUNT)
				close_window(1'b0);
		end
	endtask

	// ---------------------------------------------------------------- monitor and checker

	task automatic report_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
	endtask

	always @(posedge clk) begin
		verdict_rec_t exp_rec;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: verdict transaction with none expected, actual verdict %0d",
							$time, verdict);
				end else begin
					exp_rec = pending_verdicts.pop_front();
					verdicts_checked++;
					verdict_hits[exp_rec.verdict]++;
					if (verdict !== exp_rec.verdict)
						report_field("verdict", exp_rec.verdict, verdict);
					if (byte_count !== exp_rec.byte_count)
						report_field("byte_count", exp_rec.byte_count, byte_count);
					if (error_byte !== exp_rec.error_byte)
						report_field("error_byte", exp_rec.error_byte, error_byte);
					if (data_word !== exp_rec.data_word)
						report_field("data_word", exp_rec.data_word, data_word);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_PACKET_FORMAT)
					fmt_sel = cfg_data[0];
				else
					bcast = cfg_data;
			end
			if (in_valid && !in_stall)
				model_item(mode, rx_byte, expected_id, expected_count);
		end
	end

	// Watchdog: end the run if it hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- idling

	// Mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Receiver back-pressure: random stall bursts, quiet while steady_out is set
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (steady_out || $urandom_range(0, 99) < 60) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				repeat (pick_gap() + 1) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus primitives

	// Present one transaction, hold it until accepted, then idle or keep valid high
	task automatic send_item(input logic [1:0] m, input logic [7:0] b, input logic [7:0] id,
			input logic [7:0] cnt);
		int unsigned gap;
		in_valid       <= 1'b1;
		mode           <= m;
		rx_byte        <= b;
		expected_id    <= id;
		expected_count <= cnt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = steady_in ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic begin_window(input logic [7:0] id, input logic [7:0] cnt);
		send_item(MODE_BEGIN, 8'($urandom_range(0, 255)), id, cnt);
	endtask

	task automatic send_timeout();
		send_item(MODE_TIMEOUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// Send packet bytes [from, upto); past the packet end, send random filler
	task automatic send_bytes(input int unsigned from, input int unsigned upto);
		int unsigned k;
		logic [7:0] b;
		for (k = from; k < upto; k++) begin
			b = (k < pkt.size()) ? pkt[k] : 8'($urandom_range(0, 255));
			if ($urandom_range(0, 49) == 0)
				send_item(MODE_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			send_item(MODE_BYTE, b, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end
	endtask

	// Build a well-formed status packet for the given layout in pkt
	task automatic make_packet(input logic fmt, input logic [7:0] id, input int unsigned nparams);
		int unsigned len;
		int unsigned k;
		logic [7:0] s;
		len = fmt ? 10 + nparams : 7 + nparams;
		pkt.delete();
		for (k = 0; k < len; k++)
			pkt.push_back(8'($urandom_range(0, 255)));
		for (k = 0; k < SUM_START; k++)
			pkt[k] = HEADER_BYTE;
		pkt[fmt ? ID_POS_P2 : ID_POS_P1] = id;
		pkt[fmt ? LEN_POS_P2 : LEN_POS_P1] = 8'(len) - (fmt ? INST_POS_P2 : INST_POS_P1);
		s = '0;
		for (k = SUM_START; k < len - 1; k++)
			s = s + pkt[k];
		pkt[len - 1] = SUM_GOOD - s;
	endtask

	// Drop valid, wait for every verdict, then cover items still in flight
	task automatic drain_and_hold();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cfg_writes++;
		if (idx == REG_PACKET_FORMAT)
			drv_fmt = val[0];
		else
			drv_bcast = val;
	endtask

	// ---------------------------------------------------------------- tests

	// Zero expected count closes at once, plainly and for the broadcast id
	task automatic test_zero_count();
		begin_window(8'h00, 8'd0);
		begin_window(drv_bcast, 8'd0);
	endtask

	// Byte, timeout and unused mode with no window open produce nothing
	task automatic test_ignored_items();
		send_item(MODE_BYTE, 8'hFF, 8'h00, 8'h00);
		send_timeout();
		send_item(MODE_UNUSED, 8'h00, 8'hFF, 8'hFF);
	endtask

	task automatic test_timeout_early();
		begin_window(8'h5A, 8'd10);
		send_item(MODE_BYTE, HEADER_BYTE, 8'h00, 8'h00);
		send_item(MODE_BYTE, HEADER_BYTE, 8'h00, 8'h00);
		send_timeout();
	endtask

	task automatic test_good_packet();
		make_packet(drv_fmt, 8'h00, 2);
		begin_window(8'h00, 8'(pkt.size()));
		send_bytes(0, pkt.size());
	endtask

	// Count below the instruction index must flag length
	task automatic test_short_length();
		make_packet(drv_fmt, 8'h21, 0);
		begin_window(8'h21, 8'd4);
		send_bytes(0, 4);
	endtask

	// Switch layout while a window is open, between bytes
	task automatic test_format_switch_mid_window();
		make_packet(1'b1, 8'h42, 1);
		begin_window(8'h42, 8'(pkt.size()));
		send_bytes(0, 4);
		drain_and_hold();
		write_reg(REG_PACKET_FORMAT, 8'd1);
		send_bytes(4, pkt.size());
		drain_and_hold();
		write_reg(REG_PACKET_FORMAT, 8'd0);
	endtask

	task automatic test_random_packets();
		int unsigned start;
		int unsigned phase;
		int unsigned kind;
		int unsigned np;
		int unsigned len;
		int unsigned cnt;
		int unsigned k;
		logic [7:0] id;
		start = useful_items;
		phase = 0;
		while (useful_items - start < RANDOM_ITEMS) begin
			if (phase % 12 == 0) begin
				// idle point: drain and move to a new register setting
				drain_and_hold();
				case ($urandom_range(0, 3))
					0: write_reg(REG_BROADCAST_ID, 8'd0);
					1: write_reg(REG_BROADCAST_ID, 8'd255);
					2: write_reg(REG_BROADCAST_ID, 8'd254);
					default: write_reg(REG_BROADCAST_ID, 8'($urandom_range(0, 255)));
				endcase
				write_reg(REG_PACKET_FORMAT, 8'($urandom_range(0, 1)));
				steady_in  = ($urandom_range(0, 4) == 0);
				steady_out = ($urandom_range(0, 4) == 0);
			end
			phase++;
			np = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
			id = 8'($urandom_range(0, 255));
			make_packet(drv_fmt, id, np);
			len = pkt.size();
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				begin_window(id, 8'(len));
				send_bytes(0, len);
			end else if (kind < 55) begin
				// corrupt one byte anywhere in the packet
				k = $urandom_range(0, len - 1);
				pkt[k] = pkt[k] ^ 8'($urandom_range(1, 255));
				begin_window(id, 8'(len));
				send_bytes(0, len);
			end else if (kind < 62) begin
				begin_window(id ^ 8'($urandom_range(1, 255)), 8'(len));
				send_bytes(0, len);
			end else if (kind < 69) begin
				// timeout before the expected count is reached
				cnt = $urandom_range(0, 1) ? len : $urandom_range(len + 1, 254);
				begin_window(id, 8'(cnt));
				send_bytes(0, $urandom_range(0, len - 1));
				send_timeout();
			end else if (kind < 75) begin
				// unknown length: the timeout closes and the packet is judged
				begin_window(id, UNKNOWN_COUNT);
				send_bytes(0, $urandom_range(0, len));
				send_timeout();
			end else if (kind < 81) begin
				cnt = $urandom_range(1, len + 4);
				begin_window(id, 8'(cnt));
				send_bytes(0, cnt);
			end else if (kind < 87) begin
				begin_window(drv_bcast, 8'(len));
				send_bytes(0, len);
			end else if (kind < 92) begin
				// begin while open: abandon a partial window
				begin_window(8'($urandom_range(0, 255)), 8'($urandom_range(1, 20)));
				send_bytes(0, $urandom_range(0, 3));
				begin_window(id, 8'(len));
				send_bytes(0, len);
			end else if (kind < 96) begin
				cnt = $urandom_range(0, 3);
				begin_window(id, 8'(cnt));
				send_bytes(0, cnt);
			end else begin
				send_item(MODE_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				send_timeout();
				send_item(MODE_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				begin_window(id, 8'(len));
				send_bytes(0, len);
			end
		end
	endtask

	// Longest windows: 255 bytes closed by the saturating count, and one cut off by an expected count of 200
	task automatic test_max_count();
		logic [7:0] id;
		drain_and_hold();
		write_reg(REG_BROADCAST_ID, 8'd254);
		write_reg(REG_PACKET_FORMAT, 8'd0);
		id = 8'($urandom_range(0, 253));
		make_packet(1'b0, id, 248);
		begin_window(id, UNKNOWN_COUNT);
		send_bytes(0, pkt.size());
		drain_and_hold();
		write_reg(REG_PACKET_FORMAT, 8'd1);
		make_packet(1'b1, id, 245);
		begin_window(id, 8'd200);
		send_bytes(0, pkt.size());
		begin_window(id, UNKNOWN_COUNT);
		send_bytes(0, 255);
	endtask

	// ---------------------------------------------------------------- main sequence

	initial begin
		int unsigned codes_hit;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		mode           = MODE_BEGIN;
		rx_byte        = '0;
		expected_id    = '0;
		expected_count = '0;
		cfg_we         = 1'b0;
		cfg_index      = REG_PACKET_FORMAT;
		cfg_data       = '0;
		steady_in      = 1'b0;
		steady_out     = 1'b0;
		useful_items     = 0;
		verdicts_checked = 0;
		mismatches       = 0;
		cfg_writes       = 0;
		cycles           = 0;
		foreach (verdict_hits[i])
			verdict_hits[i] = 0;
		// reset values of the registers and the window
		fmt_sel    = 1'b0;
		bcast      = 8'd254;
		drv_fmt    = 1'b0;
		drv_bcast  = 8'd254;
		win_open   = 1'b0;
		n_rcvd     = '0;
		want_count = '0;
		want_id    = '0;
		hdr_ok     = 1'b1;
		cap_id     = '0;
		cap_len    = '0;
		cap_err    = '0;
		cap_data   = '0;
		sum8       = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_count();
		test_ignored_items();
		test_timeout_early();
		test_good_packet();
		test_short_length();
		test_format_switch_mid_window();
		test_random_packets();
		test_max_count();

		drain_and_hold();
		repeat (8) @(posedge clk);

		codes_hit = 0;
		foreach (verdict_hits[i])
			if (verdict_hits[i] != 0)
				codes_hit++;
		$display("Covered %0d transactions, %0d verdicts checked, %0d register writes",
			useful_items, verdicts_checked, cfg_writes);
		$display("Distinct verdict codes seen: %0d of 7, mismatches: %0d", codes_hit, mismatches);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
